[rtl/dqe_pkg.sv]
// Shared types, constants and helpers for the DNS question-name encoder.
package dqe_pkg;

    localparam int ADDR_W             = 9;
    localparam int CHAR_W             = 8;
    localparam int NAME_MAX_DEFAULT   = 255;
    localparam int LABEL_MAX_DEFAULT  = 63;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;

    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_W-1:0]    byte_addr;
        logic [CHAR_W-1:0]    byte_value;
        logic                 done_res;
        logic                 status;
        logic                 root_follows;
        logic [ADDR_W-1:0]    root_addr;
    } cmd_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        logic r;
        r = (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]});
        return r;
    endfunction

endpackage

[rtl/dqe_front.sv]
// Front end: accepts host-name characters, validates them and issues write commands.
module dqe_front #(
    parameter int NAME_MAX_CHARS  = dqe_pkg::NAME_MAX_DEFAULT,
    parameter int LABEL_MAX_CHARS = dqe_pkg::LABEL_MAX_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [dqe_pkg::CHAR_W-1:0]    char_code,
    output logic                          cmd_push,
    output dqe_pkg::cmd_t                 cmd
);
    import dqe_pkg::*;

    localparam int CNT_W = $clog2(LABEL_MAX_CHARS + 1);

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              at_start_reg, at_start_next;
    logic              lead_dot_reg, lead_dot_next;
    logic              err_reg, err_next;
    logic [ADDR_W-1:0] pos_inc;
    logic              issue;

    assign pos_inc = pos_reg + 1'b1;

    always_comb
    begin
        pos_next      = pos_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        at_start_next = at_start_reg;
        lead_dot_next = lead_dot_reg;
        err_next      = err_reg;
        issue         = 1'b0;
        cmd           = '0;
        if (char_code == CHAR_NUL)
        begin
            issue    = 1'b1;
            cmd.done_res = 1'b1;
            if (err_reg || pos_reg == '0)
            begin
                cmd.status = 1'b1;
            end
            else if (lead_dot_reg)
            begin
                cmd.write_enable = 1'b1;
            end
            else if (at_start_reg)
            begin
                cmd.write_enable = 1'b1;
                cmd.byte_addr    = start_reg;
            end
            else
            begin
                cmd.write_enable = 1'b1;
                cmd.byte_addr    = start_reg;
                cmd.byte_value   = CHAR_W'(count_reg);
                cmd.done_res     = 1'b0;
                cmd.root_follows = 1'b1;
                cmd.root_addr    = pos_inc;
            end
            pos_next      = '0;
            start_next    = '0;
            count_next    = '0;
            at_start_next = 1'b1;
            lead_dot_next = 1'b0;
            err_next      = 1'b0;
        end
        else if (err_reg)
        begin
            err_next = 1'b1;
        end
        else if (lead_dot_reg || pos_reg >= ADDR_W'(NAME_MAX_CHARS))
        begin
            err_next = 1'b1;
        end
        else if (pos_reg == '0 && char_code == CHAR_DOT)
        begin
            lead_dot_next = 1'b1;
            pos_next      = pos_inc;
        end
        else if (at_start_reg)
        begin
            if (!is_alnum(char_code))
            begin
                err_next = 1'b1;
            end
            else
            begin
                issue            = 1'b1;
                cmd.write_enable = 1'b1;
                cmd.byte_addr    = pos_inc;
                cmd.byte_value   = char_code;
                count_next       = CNT_W'(1);
                at_start_next    = 1'b0;
                pos_next         = pos_inc;
            end
        end
        else if (char_code == CHAR_DOT)
        begin
            issue            = 1'b1;
            cmd.write_enable = 1'b1;
            cmd.byte_addr    = start_reg;
            cmd.byte_value   = CHAR_W'(count_reg);
            start_next       = pos_inc;
            count_next       = '0;
            at_start_next    = 1'b1;
            pos_next         = pos_inc;
        end
        else if (!(is_alnum(char_code) || char_code == CHAR_HYPHEN) ||
                 count_reg >= CNT_W'(LABEL_MAX_CHARS))
        begin
            err_next = 1'b1;
        end
        else
        begin
            issue            = 1'b1;
            cmd.write_enable = 1'b1;
            cmd.byte_addr    = pos_inc;
            cmd.byte_value   = char_code;
            count_next       = count_reg + 1'b1;
            pos_next         = pos_inc;
        end
    end

    assign cmd_push = accept && issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            at_start_reg <= 1'b1;
            lead_dot_reg <= 1'b0;
            err_reg      <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            at_start_reg <= at_start_next;
            lead_dot_reg <= lead_dot_next;
            err_reg      <= err_next;
        end
    end

endmodule

[rtl/dqe_queue.sv]
// Short command queue between the front end and the result stage.
module dqe_queue #(
    parameter int DEPTH = dqe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  dqe_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output dqe_pkg::cmd_t rd_data,
    output logic          q_full,
    output logic          q_empty
);
    import dqe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/dqe_back.sv]
// Result stage: expands queued commands into result beats held in an output register.
module dqe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dqe_pkg::cmd_t                head,
    input  logic                         head_empty,
    output logic                         head_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic                         write_enable,
    output logic [dqe_pkg::ADDR_W-1:0]   byte_addr,
    output logic [dqe_pkg::CHAR_W-1:0]   byte_value,
    output logic                         done_res,
    output logic                         status
);
    import dqe_pkg::*;

    logic              valid_reg;
    logic              root_pend_reg;
    logic [ADDR_W-1:0] root_addr_reg;
    logic              we_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CHAR_W-1:0] value_reg;
    logic              done_reg;
    logic              status_reg;
    logic              load;

    assign load     = !valid_reg || pop;
    assign head_pop = load && !root_pend_reg && !head_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            root_pend_reg <= 1'b0;
        end
        else if (load)
        begin
            if (root_pend_reg)
            begin
                valid_reg     <= 1'b1;
                root_pend_reg <= 1'b0;
            end
            else if (!head_empty)
            begin
                valid_reg     <= 1'b1;
                root_pend_reg <= head.root_follows;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (root_pend_reg)
            begin
                we_reg     <= 1'b1;
                addr_reg   <= root_addr_reg;
                value_reg  <= '0;
                done_reg   <= 1'b1;
                status_reg <= 1'b0;
            end
            else if (!head_empty)
            begin
                we_reg        <= head.write_enable;
                addr_reg      <= head.byte_addr;
                value_reg     <= head.byte_value;
                done_reg      <= head.done_res;
                status_reg    <= head.status;
                root_addr_reg <= head.root_addr;
            end
        end
    end

    assign empty        = !valid_reg;
    assign write_enable = we_reg;
    assign byte_addr    = addr_reg;
    assign byte_value   = value_reg;
    assign done_res     = done_reg;
    assign status       = status_reg;

endmodule

[rtl/dns_qname_encoder_core.sv]
// Top level of the DNS question-name encoder.
// A result reaches the result ports through the command queue and then the output register.
// Throughput: one character per cycle unless full; a name ending inside a label gives two beats.
// The four-entry command queue absorbs the extra beat and output stalls before full rises.
// Reset: asynchronous, active low; clears the name state, empties the queue and output stage.
module dns_qname_encoder_core #(
    parameter int NAME_MAX_CHARS  = dqe_pkg::NAME_MAX_DEFAULT,
    parameter int LABEL_MAX_CHARS = dqe_pkg::LABEL_MAX_DEFAULT,
    parameter int QUEUE_DEPTH     = dqe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [dqe_pkg::CHAR_W-1:0]   char_code,
    input  logic                         pop,
    output logic                         empty,
    output logic                         write_enable,
    output logic [dqe_pkg::ADDR_W-1:0]   byte_addr,
    output logic [dqe_pkg::CHAR_W-1:0]   byte_value,
    output logic                         done_res,
    output logic                         status
);
    import dqe_pkg::*;

    cmd_t cmd;
    cmd_t head;
    logic cmd_push;
    logic head_pop;
    logic q_full;
    logic q_empty;

    assign full = q_full;

    dqe_front #(
        .NAME_MAX_CHARS  (NAME_MAX_CHARS),
        .LABEL_MAX_CHARS (LABEL_MAX_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !q_full),
        .char_code (char_code),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    dqe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (head_pop),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    dqe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_empty   (q_empty),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .write_enable (write_enable),
        .byte_addr    (byte_addr),
        .byte_value   (byte_value),
        .done_res     (done_res),
        .status       (status)
    );

endmodule

[rtl/dqe_checker.sv]
// Port-level checker for the DNS question-name encoder, bound to the top level.
module dqe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pop,
    input logic                         empty,
    input logic                         write_enable,
    input logic [dqe_pkg::ADDR_W-1:0]   byte_addr,
    input logic [dqe_pkg::CHAR_W-1:0]   byte_value,
    input logic                         done_res,
    input logic                         status
);

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(byte_addr) && $stable(byte_value) &&
                              $stable(write_enable) && $stable(done_res) && $stable(status)))
        else $error("waiting result beat changed");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> done_res)
        else $error("error status without done");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> (!write_enable && byte_addr == '0 && byte_value == '0))
        else $error("error beat carries a write");

    a_mid_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !done_res) |-> (write_enable && !status))
        else $error("intermediate beat without write");

endmodule

bind dns_qname_encoder_core dqe_checker u_dqe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop          (pop),
    .empty        (empty),
    .write_enable (write_enable),
    .byte_addr    (byte_addr),
    .byte_value   (byte_value),
    .done_res     (done_res),
    .status       (status)
);

[bench/dns_qname_encoder_core_tb.sv]
// Self-checking testbench for the DNS question-name encoder core with a built-in encoding predictor.
`timescale 1ns / 100ps

module dns_qname_encoder_core_tb;

    import dqe_pkg::*;

    localparam int NAME_LIMIT  = NAME_MAX_DEFAULT;
    localparam int LABEL_LIMIT = LABEL_MAX_DEFAULT;
    localparam int RANDOM_CHARS = 1650;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] value;
        logic              done;
        logic              bad;
    } qname_write_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [CHAR_W-1:0] char_code;
    logic              pop;
    logic              empty;
    logic              write_enable;
    logic [ADDR_W-1:0] byte_addr;
    logic [CHAR_W-1:0] byte_value;
    logic              done_res;
    logic              status;

    logic [CHAR_W-1:0] char_feed[$];
    qname_write_t      pending_writes[$];
    int                err_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                chars_queued;

    // encoder state mirror
    logic [ADDR_W-1:0] name_pos;
    logic [ADDR_W-1:0] label_base;
    logic [6:0]        label_len;
    logic              label_open;
    logic              dot_first;
    logic              name_bad;

    dns_qname_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .pop          (pop),
        .empty        (empty),
        .write_enable (write_enable),
        .byte_addr    (byte_addr),
        .byte_value   (byte_value),
        .done_res     (done_res),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic letter_or_digit(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic clear_name_state();
        name_pos   = '0;
        label_base = '0;
        label_len  = '0;
        label_open = 1'b1;
        dot_first  = 1'b0;
        name_bad   = 1'b0;
    endtask

    task automatic expect_write(input logic we, input logic [ADDR_W-1:0] addr,
                                input logic [CHAR_W-1:0] value, input logic done,
                                input logic bad);
        qname_write_t w;
        w.we    = we;
        w.addr  = addr;
        w.value = value;
        w.done  = done;
        w.bad   = bad;
        pending_writes.push_back(w);
    endtask

    task automatic encode_char(input logic [CHAR_W-1:0] c);
        if (c == CHAR_NUL)
        begin
            if (name_bad || name_pos == 0)
                expect_write(1'b0, '0, '0, 1'b1, 1'b1);
            else if (dot_first)
                expect_write(1'b1, '0, '0, 1'b1, 1'b0);
            else if (label_open)
                expect_write(1'b1, label_base, '0, 1'b1, 1'b0);
            else
            begin
                expect_write(1'b1, label_base, CHAR_W'(label_len), 1'b0, 1'b0);
                expect_write(1'b1, name_pos + 1'b1, '0, 1'b1, 1'b0);
            end
            clear_name_state();
        end
        else if (name_bad)
        begin
        end
        else if (dot_first || name_pos >= NAME_LIMIT)
            name_bad = 1'b1;
        else if (name_pos == 0 && c == CHAR_DOT)
        begin
            dot_first = 1'b1;
            name_pos  = ADDR_W'(1);
        end
        else if (label_open)
        begin
            if (!letter_or_digit(c))
                name_bad = 1'b1;
            else
            begin
                expect_write(1'b1, name_pos + 1'b1, c, 1'b0, 1'b0);
                label_len  = 7'd1;
                label_open = 1'b0;
                name_pos   = name_pos + 1'b1;
            end
        end
        else if (c == CHAR_DOT)
        begin
            expect_write(1'b1, label_base, CHAR_W'(label_len), 1'b0, 1'b0);
            label_base = name_pos + 1'b1;
            label_len  = '0;
            label_open = 1'b1;
            name_pos   = name_pos + 1'b1;
        end
        else if (!(letter_or_digit(c) || c == CHAR_HYPHEN) || label_len >= LABEL_LIMIT)
            name_bad = 1'b1;
        else
        begin
            expect_write(1'b1, name_pos + 1'b1, c, 1'b0, 1'b0);
            label_len = label_len + 1'b1;
            name_pos  = name_pos + 1'b1;
        end
    endtask

    task automatic report(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_beat();
        qname_write_t w;
        if (pending_writes.size() == 0)
            report($sformatf("unexpected beat we=%0b addr=%0d value=%0d done=%0b status=%0b",
                             write_enable, byte_addr, byte_value, done_res, status));
        else
        begin
            w = pending_writes.pop_front();
            if (write_enable !== w.we)
                report($sformatf("write_enable %0b, want %0b", write_enable, w.we));
            if (byte_addr !== w.addr)
                report($sformatf("byte_addr %0d, want %0d", byte_addr, w.addr));
            if (byte_value !== w.value)
                report($sformatf("byte_value %0d, want %0d", byte_value, w.value));
            if (done_res !== w.done)
                report($sformatf("done_res %0b, want %0b", done_res, w.done));
            if (status !== w.bad)
                report($sformatf("status %0b, want %0b", status, w.bad));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                encode_char(char_code);
            if (!push || !full)
            begin
                if (char_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push      <= 1'b1;
                    char_code <= char_feed.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                check_beat();
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [CHAR_W-1:0] pick_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 10)
            return CHAR_W'("0" + r);
        else if (r < 36)
            return CHAR_W'("A" + r - 10);
        return CHAR_W'("a" + r - 36);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_ldh();
        if ($urandom_range(99) < 15)
            return CHAR_HYPHEN;
        return pick_alnum();
    endfunction

    task automatic queue_char(input logic [CHAR_W-1:0] c);
        char_feed.push_back(c);
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
        queue_char(CHAR_NUL);
    endtask

    task automatic queue_label(input int n);
        queue_char(pick_alnum());
        for (int i = 1; i < n; i++)
            queue_char(pick_ldh());
    endtask

    task automatic queue_random_name();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 4)
        begin
            // 63-char labels back to back; runs one past the name limit at most
            n = $urandom_range(NAME_LIMIT - 1, NAME_LIMIT + 1);
            for (int i = 0; i < n; i++)
                queue_char((i % 64 == 63) ? CHAR_DOT : pick_ldh());
        end
        else if (kind < 12)
        begin
            queue_label($urandom_range(LABEL_LIMIT - 1, LABEL_LIMIT + 1));
            if ($urandom_range(1))
            begin
                queue_char(CHAR_DOT);
                queue_label($urandom_range(1, 4));
            end
        end
        else if (kind < 82)
        begin
            n = $urandom_range(1, 4);
            for (int l = 0; l < n; l++)
            begin
                if (l != 0)
                    queue_char(CHAR_DOT);
                queue_label($urandom_range(1, 12));
            end
            if ($urandom_range(99) < 20)
                queue_char(CHAR_DOT);
        end
        else
        begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(2))
                    0: queue_char(CHAR_DOT);
                    1: queue_char(pick_alnum());
                    default: queue_char(CHAR_W'($urandom_range(1, 255)));
                endcase
            end
        end
        queue_char(CHAR_NUL);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (char_feed.size() != 0 || push || pending_writes.size() != 0);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        chars_queued   = 0;
        while (chars_queued < count)
            queue_random_name();
        drain();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        char_code      = '0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        chars_queued   = 0;
        clear_name_state();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_text("");
        queue_text(".");
        queue_text("a.");
        queue_text(".a");
        queue_text("Z9-.z");
        queue_text("-");
        queue_text("a..");
        queue_char(8'hFF);
        queue_char(CHAR_NUL);
        drain();

        run_random_phase(0, 0, RANDOM_CHARS / 4);
        run_random_phase(50, 0, RANDOM_CHARS / 4);
        run_random_phase(0, 50, RANDOM_CHARS / 4);
        run_random_phase(16, 16, RANDOM_CHARS / 4);

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("dns_qname_encoder_core regression: pass");
        else
            $display("dns_qname_encoder_core regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("dns_qname_encoder_core regression: fail");
        $finish;
    end

endmodule
